>>> rtl/efa_pkg.sv
// Package: shared types and constants of the event fragment assembler.
`timescale 1ns / 1ps
package efa_pkg;
    localparam int MASK_W = 34;
    localparam logic [MASK_W-1:0] RESET_MASK = 34'h0_0000_0FF1;

    localparam logic [1:0] REPLY_ACK       = 2'd0;
    localparam logic [1:0] REPLY_HANDLE    = 2'd1;
    localparam logic [1:0] REPLY_POP_EMPTY = 2'd2;

    localparam logic [1:0] ORDER_NEXT      = 2'd0;
    localparam logic [1:0] ORDER_AHEAD     = 2'd1;
    localparam logic [1:0] ORDER_BACKWARDS = 2'd2;

    localparam logic KIND_FRAGMENT = 1'b0;
    localparam logic KIND_POP      = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        ignored;
        logic [5:0]  device;
        logic [31:0] trig_num;
        logic [15:0] handle;
    } q_entry_t;
endpackage

>>> rtl/efa_front.sv
// Front end: accepts transactions, classifies them, computes the slot and queues them.
`timescale 1ns / 1ps
module efa_front #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int DEVICE_COUNT = 34,
    parameter int SW           = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [5:0]                  s_device,
    input  logic [31:0]                 s_trig_num,
    input  logic [15:0]                 s_fragment_handle,
    input  logic [efa_pkg::MASK_W-1:0]  mask,
    input  logic                        hold,
    output logic                        q_valid,
    output efa_pkg::q_entry_t           q_head,
    output logic [SW-1:0]               q_slot,
    input  logic                        q_pop
);
    localparam bit POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam int RW   = $clog2(TABLE_DEPTH) + 1;

    logic              work_valid_reg;
    efa_pkg::q_entry_t work_reg;
    logic [31:0]       work_shift_reg;
    logic [RW-1:0]     work_rem_reg;
    logic [3:0]        work_cnt_reg;

    efa_pkg::q_entry_t q_reg [2];
    logic [SW-1:0]     qs_reg [2];
    logic [1:0]        qcnt_reg;

    logic [efa_pkg::MASK_W-1:0] mask_sh;
    logic          in_ign;
    logic [RW-1:0] rem_next;
    logic          work_done;
    logic [SW-1:0] work_slot;
    logic          push;
    logic          push_head;
    logic          accept;

    always_comb begin
        mask_sh = mask >> s_device;
        in_ign  = ({1'b0, s_device} >= 7'(DEVICE_COUNT)) ||
                  ({1'b0, s_device} >= 7'(efa_pkg::MASK_W)) || !mask_sh[0];
    end

    always_comb begin
        logic [RW-1:0] t;
        t = work_rem_reg;
        for (int i = 0; i < 4; i++) begin
            t = {t[RW-2:0], work_shift_reg[31-i]};
            if (t >= RW'(TABLE_DEPTH)) begin
                t = t - RW'(TABLE_DEPTH);
            end
        end
        rem_next = t;
    end

    assign work_done = POW2 ? 1'b1 : (work_cnt_reg == 4'd0);
    assign work_slot = POW2 ? work_reg.trig_num[SW-1:0] : work_rem_reg[SW-1:0];
    assign push      = work_valid_reg && work_done && (qcnt_reg != 2'd2);
    assign push_head = push && ((qcnt_reg == 2'd0) || (qcnt_reg == 2'd1 && q_pop));
    assign s_ready   = !work_valid_reg && !hold;
    assign accept    = s_valid && s_ready;
    assign q_valid   = qcnt_reg != 2'd0;
    assign q_head    = q_reg[0];
    assign q_slot    = qs_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else if (accept) begin
            work_valid_reg <= 1'b1;
        end else if (push) begin
            work_valid_reg <= 1'b0;
        end
        if (accept) begin
            work_reg       <= '{kind: s_kind, ignored: in_ign, device: s_device,
                                trig_num: s_trig_num, handle: s_fragment_handle};
            work_shift_reg <= s_trig_num;
            work_rem_reg   <= '0;
            work_cnt_reg   <= 4'd8;
        end else if (work_valid_reg && !work_done) begin
            work_rem_reg   <= rem_next;
            work_shift_reg <= work_shift_reg << 4;
            work_cnt_reg   <= work_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qcnt_reg <= 2'd0;
        end else begin
            qcnt_reg <= qcnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
        if (push_head) begin
            q_reg[0]  <= work_reg;
            qs_reg[0] <= work_slot;
        end else if (q_pop) begin
            q_reg[0]  <= q_reg[1];
            qs_reg[0] <= qs_reg[1];
        end
        if (push && !push_head) begin
            q_reg[1]  <= work_reg;
            qs_reg[1] <= work_slot;
        end
    end
endmodule

>>> rtl/efa_back.sv
// Back end: slot table, handle store, ready stack and result sequencing.
`timescale 1ns / 1ps
module efa_back #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int DEVICE_COUNT = 34,
    parameter int STACK_DEPTH  = 128,
    parameter int SW           = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [efa_pkg::MASK_W-1:0]  mask,
    output logic                        clearing,
    input  logic                        q_valid,
    input  efa_pkg::q_entry_t           q_head,
    input  logic [SW-1:0]               q_slot,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_reply_kind,
    output logic                        m_ignored,
    output logic [1:0]                  m_order_status,
    output logic                        m_collision,
    output logic                        m_completed,
    output logic                        m_dropped,
    output logic [31:0]                 m_event_out,
    output logic [5:0]                  m_device_out,
    output logic [15:0]                 m_handle_out,
    output logic                        m_last
);
    localparam int MW  = efa_pkg::MASK_W;
    localparam int DW  = DEVICE_COUNT > 1 ? $clog2(DEVICE_COUNT) : 1;
    localparam int HAW = $clog2(TABLE_DEPTH * DEVICE_COUNT);
    localparam int STW = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FRAG  = 3'd1;
    localparam logic [2:0] ST_POPRD = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_HRD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [31+MW:0]  slot_mem [TABLE_DEPTH];
    logic [31:0]     ls_mem [DEVICE_COUNT];
    logic [15:0]     hdl_mem [TABLE_DEPTH * DEVICE_COUNT];
    logic [31+SW:0]  stk_mem [STACK_DEPTH];

    logic [31+MW:0]  slot_rd;
    logic [31:0]     ls_rd;
    logic [15:0]     hdl_rd;
    logic [31+SW:0]  stk_rd;

    logic [2:0]              state_reg;
    logic                    clr_reg;
    logic [SW-1:0]           clr_addr_reg;
    logic [CW-1:0]           cnt_reg;
    logic [DEVICE_COUNT-1:0] ls_valid_reg;
    efa_pkg::q_entry_t       cur_reg;
    logic [SW-1:0]           slot_reg;
    logic [5:0]              dev_idx_reg;
    logic                    out_valid_reg;
    logic [1:0]              o_kind_reg;
    logic                    o_ign_reg;
    logic [1:0]              o_ord_reg;
    logic                    o_col_reg;
    logic                    o_comp_reg;
    logic                    o_drop_reg;
    logic [31:0]             o_ev_reg;
    logic [5:0]              o_dev_reg;
    logic [15:0]             o_hdl_reg;
    logic                    o_last_reg;

    logic [MW-1:0]  dev_lim;
    logic [MW-1:0]  mask_lim;
    logic [MW-1:0]  scan_rest;
    logic [MW-1:0]  scan_after;
    logic [31:0]    ls_val;
    logic [31:0]    next_ev;
    logic [1:0]     ord;
    logic [MW-1:0]  row_dev;
    logic [31:0]    row_ev;
    logic [MW-1:0]  dev_bit;
    logic           same_slot;
    logic [MW-1:0]  new_dev;
    logic           comp;
    logic           full;
    logic [HAW-1:0] hdl_waddr;
    logic [HAW-1:0] hdl_raddr;
    logic           slot_we;
    logic [31+MW:0] slot_wdata;
    logic [SW-1:0]  slot_waddr;
    logic           stk_we;
    logic           idle_go;

    always_comb begin
        for (int i = 0; i < MW; i++) begin
            dev_lim[i] = i < DEVICE_COUNT;
        end
        mask_lim   = mask & dev_lim;
        scan_rest  = mask_lim >> dev_idx_reg;
        scan_after = mask_lim >> ({1'b0, dev_idx_reg} + 7'd1);
        row_ev     = slot_rd[31+MW:MW];
        row_dev    = slot_rd[MW-1:0];
        ls_val     = ls_valid_reg[cur_reg.device[DW-1:0]] ? ls_rd : 32'd0;
        next_ev    = ls_val + 32'd1;
        if (cur_reg.trig_num == next_ev) begin
            ord = efa_pkg::ORDER_NEXT;
        end else if (cur_reg.trig_num > next_ev) begin
            ord = efa_pkg::ORDER_AHEAD;
        end else begin
            ord = efa_pkg::ORDER_BACKWARDS;
        end
        dev_bit   = MW'(1) << cur_reg.device;
        same_slot = (row_dev == '0) || (row_ev == cur_reg.trig_num);
        new_dev   = same_slot ? (row_dev | dev_bit) : dev_bit;
        comp      = new_dev == mask;
        full      = cnt_reg == CW'(STACK_DEPTH);
        hdl_waddr = HAW'(slot_reg) * HAW'(DEVICE_COUNT) + HAW'(cur_reg.device);
        hdl_raddr = HAW'(slot_reg) * HAW'(DEVICE_COUNT) + HAW'(dev_idx_reg);
        slot_we   = clr_reg || (state_reg == ST_FRAG);
        slot_waddr = clr_reg ? clr_addr_reg : slot_reg;
        slot_wdata = clr_reg ? '0 : {cur_reg.trig_num, comp ? MW'(0) : new_dev};
        stk_we    = (state_reg == ST_FRAG) && comp && !full;
        idle_go   = (state_reg == ST_IDLE) && !clr_reg && q_valid;
    end

    assign q_pop    = idle_go;
    assign clearing = clr_reg;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (idle_go) begin
            slot_rd <= slot_mem[q_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FRAG) begin
            ls_mem[cur_reg.device[DW-1:0]] <= cur_reg.trig_num;
        end
        if (idle_go) begin
            ls_rd <= ls_mem[q_head.device[DW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FRAG) begin
            hdl_mem[hdl_waddr] <= cur_reg.handle;
        end
        if (state_reg == ST_SCAN) begin
            hdl_rd <= hdl_mem[hdl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[cnt_reg[STW-1:0]] <= {cur_reg.trig_num, slot_reg};
        end
        if (idle_go && q_head.kind == efa_pkg::KIND_POP && cnt_reg != '0) begin
            stk_rd <= stk_mem[STW'(cnt_reg - CW'(1))];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            ls_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + SW'(1);
                if (clr_addr_reg == SW'(TABLE_DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (idle_go) begin
                        cur_reg  <= q_head;
                        slot_reg <= q_slot;
                        o_ign_reg  <= 1'b0;
                        o_ord_reg  <= efa_pkg::ORDER_NEXT;
                        o_col_reg  <= 1'b0;
                        o_comp_reg <= 1'b0;
                        o_drop_reg <= 1'b0;
                        o_hdl_reg  <= '0;
                        o_last_reg <= 1'b1;
                        if (q_head.kind == efa_pkg::KIND_POP) begin
                            if (cnt_reg == '0) begin
                                o_kind_reg    <= efa_pkg::REPLY_POP_EMPTY;
                                o_ev_reg      <= '0;
                                o_dev_reg     <= '0;
                                out_valid_reg <= 1'b1;
                                state_reg     <= ST_OUT;
                            end else begin
                                cnt_reg   <= cnt_reg - CW'(1);
                                state_reg <= ST_POPRD;
                            end
                        end else if (q_head.ignored) begin
                            o_kind_reg    <= efa_pkg::REPLY_ACK;
                            o_ign_reg     <= 1'b1;
                            o_ev_reg      <= q_head.trig_num;
                            o_dev_reg     <= q_head.device;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end else begin
                            state_reg <= ST_FRAG;
                        end
                    end
                end
                ST_FRAG: begin
                    ls_valid_reg[cur_reg.device[DW-1:0]] <= 1'b1;
                    if (stk_we) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    o_kind_reg    <= efa_pkg::REPLY_ACK;
                    o_ord_reg     <= ord;
                    o_col_reg     <= !same_slot;
                    o_comp_reg    <= comp;
                    o_drop_reg    <= comp && full;
                    o_ev_reg      <= cur_reg.trig_num;
                    o_dev_reg     <= cur_reg.device;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_POPRD: begin
                    o_ev_reg    <= stk_rd[31+SW:SW];
                    slot_reg    <= stk_rd[SW-1:0];
                    dev_idx_reg <= '0;
                    state_reg   <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (scan_rest == '0) begin
                        state_reg <= ST_IDLE;
                    end else if (scan_rest[0]) begin
                        state_reg <= ST_HRD;
                    end else begin
                        dev_idx_reg <= dev_idx_reg + 6'd1;
                    end
                end
                ST_HRD: begin
                    o_kind_reg    <= efa_pkg::REPLY_HANDLE;
                    o_dev_reg     <= dev_idx_reg;
                    o_hdl_reg     <= hdl_rd;
                    o_last_reg    <= scan_after == '0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        out_valid_reg <= 1'b0;
                        if (o_kind_reg == efa_pkg::REPLY_HANDLE && !o_last_reg) begin
                            dev_idx_reg <= dev_idx_reg + 6'd1;
                            state_reg   <= ST_SCAN;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_reply_kind   = o_kind_reg;
    assign m_ignored      = o_ign_reg;
    assign m_order_status = o_ord_reg;
    assign m_collision    = o_col_reg;
    assign m_completed    = o_comp_reg;
    assign m_dropped      = o_drop_reg;
    assign m_event_out    = o_ev_reg;
    assign m_device_out   = o_dev_reg;
    assign m_handle_out   = o_hdl_reg;
    assign m_last         = o_last_reg;
endmodule

>>> rtl/event_fragment_assembler.sv
// Top level: mask register, front end, back end and checks.
// Slot: taken from the low trigger-number bits when the table depth is a power of two,
// else computed by the 4-bit-per-cycle slot remainder unit in the front end.
// Fragments are paced by the slot table read-modify-write, and the front end can accept
// the next one meanwhile; a pop gives one result per masked device, paced by the scan.
// Reset: synchronous active-low; a clearing pass then empties the slot table,
// during which no transaction is accepted.
`timescale 1ns / 1ps
module event_fragment_assembler #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int DEVICE_COUNT = 34,
    parameter int STACK_DEPTH  = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [efa_pkg::MASK_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [5:0]                  s_device,
    input  logic [31:0]                 s_trig_num,
    input  logic [15:0]                 s_fragment_handle,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_reply_kind,
    output logic                        m_ignored,
    output logic [1:0]                  m_order_status,
    output logic                        m_collision,
    output logic                        m_completed,
    output logic                        m_dropped,
    output logic [31:0]                 m_event_out,
    output logic [5:0]                  m_device_out,
    output logic [15:0]                 m_handle_out,
    output logic                        m_last
);
    localparam int SW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;

    logic [efa_pkg::MASK_W-1:0] mask_reg;
    logic              clearing;
    logic              q_valid;
    efa_pkg::q_entry_t q_head;
    logic [SW-1:0]     q_slot;
    logic              q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= efa_pkg::RESET_MASK;
        end else if (cfg_wr_en) begin
            mask_reg <= cfg_wr_data;
        end
    end

    efa_front #(.TABLE_DEPTH(TABLE_DEPTH), .DEVICE_COUNT(DEVICE_COUNT), .SW(SW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_device(s_device),
        .s_trig_num(s_trig_num), .s_fragment_handle(s_fragment_handle),
        .mask(mask_reg), .hold(clearing),
        .q_valid(q_valid), .q_head(q_head), .q_slot(q_slot), .q_pop(q_pop)
    );

    efa_back #(.TABLE_DEPTH(TABLE_DEPTH), .DEVICE_COUNT(DEVICE_COUNT),
               .STACK_DEPTH(STACK_DEPTH), .SW(SW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .mask(mask_reg), .clearing(clearing),
        .q_valid(q_valid), .q_head(q_head), .q_slot(q_slot), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_reply_kind(m_reply_kind),
        .m_ignored(m_ignored), .m_order_status(m_order_status),
        .m_collision(m_collision), .m_completed(m_completed), .m_dropped(m_dropped),
        .m_event_out(m_event_out), .m_device_out(m_device_out),
        .m_handle_out(m_handle_out), .m_last(m_last)
    );

`ifndef SYNTHESIS
    a_ign_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ignored |-> !m_completed && !m_collision && !m_dropped)
        else $error("ignored transaction carries table flags");
    a_drop_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> m_completed)
        else $error("drop without completion");
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_kind == efa_pkg::REPLY_POP_EMPTY |-> m_last && m_event_out == 32'd0)
        else $error("empty pop result malformed");
    a_no_accept_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("transaction accepted during clearing pass");
`endif
endmodule

>>> tb/event_fragment_assembler_tb.sv
// Testbench: directed and random fragment/pop transactions checked against a built-in predictor.
`timescale 1ns / 1ps
module event_fragment_assembler_tb;
    localparam int MW      = efa_pkg::MASK_W;
    localparam int TBL     = 1024;
    localparam int NDEV    = 34;
    localparam int STK     = 128;
    localparam int LIMIT   = 6000;
    localparam int SETTLE  = 20;
    localparam int ITEMS   = 430;
    localparam logic [MW-1:0] ALL_DEVICES = {MW{1'b1}};

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic        ignored;
        logic [1:0]  order_status;
        logic        collision;
        logic        completed;
        logic        dropped;
        logic [31:0] event_out;
        logic [5:0]  device_out;
        logic [15:0] handle_out;
        logic        last;
    } reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [MW-1:0]     cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_kind = efa_pkg::KIND_FRAGMENT;
    logic [5:0]        s_device = '0;
    logic [31:0]       s_trig_num = '0;
    logic [15:0]       s_fragment_handle = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_reply_kind;
    logic              m_ignored;
    logic [1:0]        m_order_status;
    logic              m_collision;
    logic              m_completed;
    logic              m_dropped;
    logic [31:0]       m_event_out;
    logic [5:0]        m_device_out;
    logic [15:0]       m_handle_out;
    logic              m_last;

    // predictor state
    logic [MW-1:0]     mask_q;
    logic [31:0]       seen_ev [NDEV];
    logic [31:0]       slot_ev [TBL];
    logic [MW-1:0]     slot_devs [TBL];
    logic [15:0]       slot_hdl [TBL][NDEV];
    logic [31:0]       ready_ev [STK];
    int                ready_cnt;

    reply_t replies_due[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     item_count = 0;
    bit     calm = 1'b0;
    logic [31:0] ev_ctr;

    event_fragment_assembler i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_device          (s_device),
        .s_trig_num        (s_trig_num),
        .s_fragment_handle (s_fragment_handle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_reply_kind      (m_reply_kind),
        .m_ignored         (m_ignored),
        .m_order_status    (m_order_status),
        .m_collision       (m_collision),
        .m_completed       (m_completed),
        .m_dropped         (m_dropped),
        .m_event_out       (m_event_out),
        .m_device_out      (m_device_out),
        .m_handle_out      (m_handle_out),
        .m_last            (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic bit in_mask(input logic [5:0] dev);
        return dev < NDEV && mask_q[dev];
    endfunction

    task automatic predict_fragment(input logic [5:0] dev, input logic [31:0] ev,
                                    input logic [15:0] hdl);
        reply_t r;
        int slot;
        logic [31:0] nxt;
        r = '0;
        r.reply_kind = efa_pkg::REPLY_ACK;
        r.event_out = ev;
        r.device_out = dev;
        r.last = 1'b1;
        if (!in_mask(dev)) begin
            r.ignored = 1'b1;
        end else begin
            nxt = seen_ev[dev] + 32'd1;
            if (ev == nxt) begin
                r.order_status = efa_pkg::ORDER_NEXT;
            end else if (ev > nxt) begin
                r.order_status = efa_pkg::ORDER_AHEAD;
            end else begin
                r.order_status = efa_pkg::ORDER_BACKWARDS;
            end
            seen_ev[dev] = ev;
            slot = ev % TBL;
            if (slot_devs[slot] == '0 || slot_ev[slot] == ev) begin
                slot_devs[slot][dev] = 1'b1;
            end else begin
                slot_devs[slot] = '0;
                slot_devs[slot][dev] = 1'b1;
                r.collision = 1'b1;
            end
            slot_ev[slot] = ev;
            slot_hdl[slot][dev] = hdl;
            if (slot_devs[slot] == mask_q) begin
                r.completed = 1'b1;
                if (ready_cnt >= STK) begin
                    r.dropped = 1'b1;
                end else begin
                    ready_ev[ready_cnt] = ev;
                    ready_cnt++;
                end
                slot_devs[slot] = '0;
            end
        end
        replies_due.push_back(r);
    endtask

    task automatic predict_pop();
        reply_t r;
        int total;
        int k;
        logic [31:0] pev;
        r = '0;
        if (ready_cnt == 0) begin
            r.reply_kind = efa_pkg::REPLY_POP_EMPTY;
            r.last = 1'b1;
            replies_due.push_back(r);
        end else begin
            ready_cnt--;
            pev = ready_ev[ready_cnt];
            total = $countones(mask_q);
            k = 0;
            for (int d = 0; d < NDEV; d++) begin
                if (mask_q[d]) begin
                    r = '0;
                    r.reply_kind = efa_pkg::REPLY_HANDLE;
                    r.event_out = pev;
                    r.device_out = d[5:0];
                    r.handle_out = slot_hdl[pev % TBL][d];
                    k++;
                    r.last = (k == total);
                    replies_due.push_back(r);
                end
            end
        end
    endtask

    task automatic send(input logic kind, input logic [5:0] dev, input logic [31:0] ev,
                        input logic [15:0] hdl);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_kind <= kind;
        s_device <= dev;
        s_trig_num <= ev;
        s_fragment_handle <= hdl;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        item_count++;
        if (kind == efa_pkg::KIND_POP) begin
            predict_pop();
        end else begin
            predict_fragment(dev, ev, hdl);
        end
    endtask

    task automatic frag(input logic [5:0] dev, input logic [31:0] ev);
        send(efa_pkg::KIND_FRAGMENT, dev, ev, 16'($urandom_range(0, 65535)));
    endtask

    task automatic pop();
        send(efa_pkg::KIND_POP, 6'($urandom_range(0, 63)), $urandom,
             16'($urandom_range(0, 65535)));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // drain the ready stack first so no pop reads a handle never written
    task automatic set_mask(input logic [MW-1:0] m);
        while (ready_cnt > 0) pop();
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mask_q = m;
    endtask

    task automatic whole_event(input logic [31:0] ev, input bit partial, input bit noisy);
        logic [5:0] devs[$];
        logic [5:0] tmp;
        int j;
        int d;
        for (int i = 0; i < NDEV; i++) if (mask_q[i]) devs.push_back(i[5:0]);
        for (int i = devs.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = devs[i];
            devs[i] = devs[j];
            devs[j] = tmp;
        end
        if (partial && devs.size() > 1) void'(devs.pop_back());
        foreach (devs[i]) begin
            if (noisy && $urandom_range(0, 7) == 0) begin
                do d = $urandom_range(0, 63); while (in_mask(d[5:0]));
                frag(d[5:0], $urandom);
            end
            if (noisy && $urandom_range(0, 19) == 0) pop();
            frag(devs[i], ev);
        end
    endtask

    task automatic test_empty_pop();
        pop();
        pop();
    endtask

    task automatic test_ordering();
        frag(6'd0, 32'd1);
        frag(6'd0, 32'd5);
        frag(6'd0, 32'd5);
        frag(6'd0, 32'd2);
        frag(6'd4, 32'hFFFF_FFFF);
        frag(6'd4, 32'd0);
        frag(6'd1, 32'd7);
        frag(6'd63, 32'hFFFF_FFFF);
        frag(6'd34, 32'd3);
        send(efa_pkg::KIND_FRAGMENT, 6'd5, 32'hFFFF_FFFF, 16'hFFFF);
        send(efa_pkg::KIND_FRAGMENT, 6'd6, 32'hFFFF_FFFF, 16'h0000);
    endtask

    task automatic test_collision();
        whole_event(32'd300, 1'b1, 1'b0);
        frag(6'd8, 32'd300 + TBL);
        whole_event(32'd300 + TBL, 1'b0, 1'b0);
        pop();
        pop();
    endtask

    task automatic test_mask_extremes();
        set_mask(ALL_DEVICES);
        whole_event(32'd40, 1'b0, 1'b0);
        pop();
        set_mask(34'd1);
        frag(6'd0, 32'h8000_0000);
        frag(6'd33, 32'd9);
        pop();
        set_mask(34'h2_0000_0000);
        frag(6'd33, 32'd77);
        pop();
    endtask

    task automatic test_stack_full();
        set_mask(34'h80);
        calm = 1'b1;
        for (int i = 0; i < STK + 3; i++) frag(6'd7, 32'd1000 + i);
        for (int i = 0; i < STK + 1; i++) pop();
        calm = 1'b0;
    endtask

    task automatic test_random();
        logic [MW-1:0] m;
        logic [31:0] ev;
        int phase;
        int events;
        int r;
        phase = 0;
        ev_ctr = 32'd2000;
        while (item_count < ITEMS) begin
            case (phase % 5)
                0: m = efa_pkg::RESET_MASK;
                1: begin
                    m = '0;
                    repeat ($urandom_range(1, 6)) m[$urandom_range(0, NDEV - 1)] = 1'b1;
                end
                2: m = ALL_DEVICES;
                3: m = {2'($urandom_range(0, 3)), $urandom} | 34'd1;
                default: m = 34'd1;
            endcase
            set_mask(m);
            events = (phase % 5 == 2 || phase % 5 == 3) ? 1 : 3;
            for (int e = 0; e < events && item_count < ITEMS; e++) begin
                calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    ev = $urandom;
                end else if (r == 1) begin
                    ev = ev_ctr - $urandom_range(1, 5);
                end else if (r == 2) begin
                    ev_ctr = ev_ctr + $urandom_range(2, 3000);
                    ev = ev_ctr;
                end else if (r == 3) begin
                    ev = ev_ctr + TBL;
                end else begin
                    ev_ctr++;
                    ev = ev_ctr;
                end
                whole_event(ev, $urandom_range(0, 7) == 0, 1'b1);
                if ($urandom_range(0, 9) < 4) pop();
            end
            phase++;
        end
        calm = 1'b0;
    endtask

    initial begin
        forever begin
            int stall;
            @(posedge aclk);
            while (!m_valid || !m_ready) @(posedge aclk);
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: event %h device %0d",
                                               m_event_out, m_device_out);
            end else begin
                reply_t got;
                reply_t want;
                want = replies_due.pop_front();
                got = {m_reply_kind, m_ignored, m_order_status, m_collision, m_completed,
                       m_dropped, m_event_out, m_device_out, m_handle_out, m_last};
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind %0d ign %0d ord %0d col %0d",
                                 want.reply_kind, want.ignored, want.order_status,
                                 want.collision);
                        $display("  cmp %0d drp %0d ev %h dev %0d hdl %h last %0d",
                                 want.completed, want.dropped, want.event_out,
                                 want.device_out, want.handle_out, want.last);
                        $display("  got kind %0d ign %0d ord %0d col %0d",
                                 got.reply_kind, got.ignored, got.order_status,
                                 got.collision);
                        $display("  cmp %0d drp %0d ev %h dev %0d hdl %h last %0d",
                                 got.completed, got.dropped, got.event_out,
                                 got.device_out, got.handle_out, got.last);
                    end
                end
            end
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
                @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        @(posedge aclk);
        m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        mask_q = efa_pkg::RESET_MASK;
        ready_cnt = 0;
        for (int i = 0; i < NDEV; i++) seen_ev[i] = '0;
        for (int i = 0; i < TBL; i++) begin
            slot_ev[i] = '0;
            slot_devs[i] = '0;
            for (int d = 0; d < NDEV; d++) slot_hdl[i][d] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_pop();
        test_ordering();
        test_collision();
        test_mask_extremes();
        test_stack_full();
        test_random();
        set_mask(efa_pkg::RESET_MASK);
        settle();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
